FILE: rtl/core/tnb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnb_pkg: shared types and constants of the best share board
// entry layout, cell control bundle, board geometry and function codes
// ----------------------------------------------------------------------------
package tnb_pkg;

	localparam int unsigned BOARD_ENTRIES = 8;
	localparam int unsigned EXTRA_BYTES   = 8;
	localparam int unsigned SLOT_W        = $clog2(BOARD_ENTRIES);
	localparam int unsigned CNT_W         = $clog2(BOARD_ENTRIES + 1);

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	// one stored share
	typedef struct packed {
		logic [63:0] key;
		logic [31:0] submit_time;
		logic [31:0] block_time;
		logic [31:0] nonce;
		logic [31:0] version_word;
		logic        ver_rolled;
		logic [63:0] hash_top;
		logic        hash_present;
		logic [63:0] extra_nonce;
		logic [3:0]  extra_nonce_len;
	} entry_t;

	// per-cell control from the board level
	typedef struct packed {
		logic ins_en;    // accepted insert that is not rejected
		logic occupied;  // cell holds a valid entry
		logic prev_take; // upper neighbor shifts its entry down
	} cell_ctl_t;

endpackage : tnb_pkg
`default_nettype wire

FILE: rtl/core/tnb_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tnb_cell: one slot of the sorted share chain
// compares the new key with its own, then loads the new share or the
// entry handed down by its upper neighbor
// ----------------------------------------------------------------------------
module tnb_cell (
	input  wire                 clk,
	input  tnb_pkg::cell_ctl_t  ctl,
	input  tnb_pkg::entry_t     new_entry,
	input  tnb_pkg::entry_t     prev_entry,
	output logic                take,
	output tnb_pkg::entry_t     entry
);
	import tnb_pkg::*;

	entry_t entry_q;

	// empty slot or strictly beaten key: new share goes here or above
	assign take  = !ctl.occupied || (new_entry.key > entry_q.key);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.ins_en && take) begin
			entry_q <= ctl.prev_take ? prev_entry : new_entry;
		end
	end

endmodule : tnb_cell
`default_nettype wire

FILE: rtl/core/top_n_best_share_board.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// top_n_best_share_board: keeps the best mining shares sorted by difficulty
// input channel (in_valid/in_ready) carries one beat per request: func 0
// inserts a share, func 1 reads the slot given by read_slot. every input
// beat gives exactly one output beat (out_valid/out_ready).
// the board is a chain of eight cells, highest difficulty in cell 0. on an
// insert every cell compares the new key with its own in parallel; the
// first cell that is beaten (or empty) takes the share, the cells below it
// take their upper neighbor's entry, and the last entry falls off a full
// board. a share is rejected (slot 8) when its key is negative, inf or nan,
// or when the board is full and the key does not beat the last entry.
// the output beat comes in the cycle after the input beat; throughput is one
// beat per cycle, set by the single compare-and-shift step of the chain.
// the output register frees as its beat is taken, so a new input beat is
// accepted in the same cycle the receiver takes the previous result. while
// the receiver stalls with a result pending, in_ready is low.
// reset clears the fill count and the output valid; the cell contents are
// not cleared, slots at or above the fill count read back as empty.
// ----------------------------------------------------------------------------
module top_n_best_share_board (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [0:0]  func,
	input  wire  [2:0]  read_slot,
	input  wire  [63:0] diff_bits,
	input  wire  [31:0] submit_time,
	input  wire  [31:0] block_time,
	input  wire  [31:0] share_nonce,
	input  wire  [31:0] version_word,
	input  wire         version_was_rolled,
	input  wire  [63:0] hash_top,
	input  wire         hash_present,
	input  wire  [63:0] extra_nonce,
	input  wire  [3:0]  extra_nonce_len,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [3:0]  slot,
	output logic [3:0]  fill,
	output logic [63:0] out_diff_bits,
	output logic [31:0] out_submit_time,
	output logic [31:0] out_block_time,
	output logic [31:0] out_nonce,
	output logic [31:0] out_version_word,
	output logic        out_version_rolled,
	output logic [63:0] out_hash_top,
	output logic        out_hash_present,
	output logic [63:0] out_extra_nonce,
	output logic [3:0]  out_extra_nonce_len
);
	import tnb_pkg::*;

	// handshake
	logic in_fire;
	logic out_valid_q;

	// board state
	logic [CNT_W-1:0] count_q;
	logic             full;

	// chain wiring
	entry_t                   new_entry;
	entry_t                   cell_entry [BOARD_ENTRIES];
	cell_ctl_t                cell_ctl   [BOARD_ENTRIES];
	logic [BOARD_ENTRIES-1:0] take_vec;

	// insert decision
	logic             key_sane;
	logic             ins_req;
	logic             ins_ok;
	logic [CNT_W-1:0] pos;
	logic [CNT_W-1:0] count_d;

	// read path
	entry_t rd_entry;
	logic   rd_hit;

	// result register
	logic [CNT_W-1:0] res_slot_d;
	entry_t           res_entry_d;
	logic [CNT_W-1:0] slot_q;
	logic [CNT_W-1:0] fill_q;
	entry_t           res_entry_q;

	// extranonce clamp and byte mask
	logic [3:0]  ext_len_c;
	logic [63:0] ext_mask;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign full     = (count_q == CNT_W'(BOARD_ENTRIES));
	// no sign bit, exponent not all ones
	assign key_sane = !diff_bits[63] && (diff_bits[62:52] != 11'h7ff);
	assign ins_req  = in_fire && (func == FUNC_INSERT);
	// the last cell takes unless the board is full and the key is not better
	assign ins_ok   = key_sane && take_vec[BOARD_ENTRIES-1];

	always_comb begin
		ext_len_c = (extra_nonce_len > 4'(EXTRA_BYTES)) ? 4'(EXTRA_BYTES) : extra_nonce_len;
		for (int b = 0; b < 8; b++) begin
			ext_mask[b*8 +: 8] = (4'(b) < ext_len_c) ? 8'hff : 8'h00;
		end
	end

	always_comb begin
		new_entry.key             = diff_bits;
		new_entry.submit_time     = submit_time;
		new_entry.block_time      = block_time;
		new_entry.nonce           = share_nonce;
		new_entry.version_word    = version_word;
		new_entry.ver_rolled      = version_was_rolled;
		new_entry.hash_top        = hash_present ? hash_top : 64'd0;
		new_entry.hash_present    = hash_present;
		new_entry.extra_nonce     = extra_nonce & ext_mask;
		new_entry.extra_nonce_len = ext_len_c;
	end

	// chain of cells, cell 0 holds the best share
	for (genvar i = 0; i < BOARD_ENTRIES; i++) begin : g_cell
		always_comb begin
			cell_ctl[i].ins_en    = ins_req && ins_ok;
			cell_ctl[i].occupied  = (CNT_W'(i) < count_q);
			cell_ctl[i].prev_take = (i == 0) ? 1'b0 : take_vec[(i == 0) ? 0 : i-1];
		end

		tnb_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.new_entry  (new_entry),
			.prev_entry (cell_entry[(i == 0) ? 0 : i-1]),
			.take       (take_vec[i]),
			.entry      (cell_entry[i])
		);
	end

	// insert position: first taking cell, takes are monotone down the chain
	always_comb begin
		pos = CNT_W'(BOARD_ENTRIES);
		for (int i = BOARD_ENTRIES - 1; i >= 0; i--) begin
			if (take_vec[i]) begin
				pos = CNT_W'(i);
			end
		end
	end

	assign count_d = full ? count_q : count_q + CNT_W'(1);

	assign rd_hit   = ({1'b0, read_slot} < CNT_W'(count_q));
	assign rd_entry = cell_entry[read_slot[SLOT_W-1:0]];

	// next result beat
	always_comb begin
		res_slot_d  = CNT_W'(BOARD_ENTRIES);
		res_entry_d = '0;
		if (func == FUNC_READ) begin
			if (rd_hit) begin
				res_slot_d  = CNT_W'(read_slot);
				res_entry_d = rd_entry;
			end
		end else if (ins_ok) begin
			res_slot_d = pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ins_req && ins_ok) begin
				count_q <= count_d;
			end
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			slot_q      <= res_slot_d;
			fill_q      <= (ins_req && ins_ok) ? count_d : count_q;
			res_entry_q <= res_entry_d;
		end
	end

	assign out_valid           = out_valid_q;
	assign slot                = slot_q;
	assign fill                = fill_q;
	assign out_diff_bits       = res_entry_q.key;
	assign out_submit_time     = res_entry_q.submit_time;
	assign out_block_time      = res_entry_q.block_time;
	assign out_nonce           = res_entry_q.nonce;
	assign out_version_word    = res_entry_q.version_word;
	assign out_version_rolled  = res_entry_q.ver_rolled;
	assign out_hash_top        = res_entry_q.hash_top;
	assign out_hash_present    = res_entry_q.hash_present;
	assign out_extra_nonce     = res_entry_q.extra_nonce;
	assign out_extra_nonce_len = res_entry_q.extra_nonce_len;

`ifndef ASSERT_OFF
	// fill count never passes the board size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BOARD_ENTRIES))
		else $error("fill count beyond board size");

	// cell takes form one contiguous run ending at the last cell
	a_take_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		((take_vec << 1) & ~take_vec) == '0)
		else $error("insert chain takes not monotone");

	// an accepted insert on a board with room grows the fill by one
	a_fill_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(ins_req && ins_ok && !full) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("fill count did not grow on insert");

	// a rejected insert or any read leaves the fill alone
	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !(ins_req && ins_ok)) |=> $stable(count_q))
		else $error("fill count changed without insert");

	// a reported slot is always below the reported fill
	a_slot_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (slot_q != CNT_W'(BOARD_ENTRIES))) |-> (slot_q < fill_q))
		else $error("result slot outside fill");
`endif

endmodule : top_n_best_share_board
`default_nettype wire

FILE: verif/top_n_best_share_board_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_n_best_share_board_tb: self-checking bench for the best share board
// sends insert and read beats in random bursts against a stalling receiver,
// predicts each result from a shadow copy of the sorted board and compares
// every output beat field by field, oldest prediction first
// ----------------------------------------------------------------------------
module top_n_best_share_board_tb;
	import tnb_pkg::*;

	localparam int unsigned DIRECTED_SHARES = 25;
	localparam int unsigned RANDOM_SHARES   = 1625;
	localparam int unsigned RX_HOLD_CYCLES  = 300;
	localparam int unsigned WATCHDOG_LIMIT  = 4000;
	localparam int unsigned REPORT_LIMIT    = 10;
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam logic [10:0] EXP_ALL_ONES    = 11'h7FF;
	localparam logic [63:0] TOP_FINITE_KEY  = 64'h7FEF_FFFF_FFFF_FFFF;

	// one request beat as the driver holds it
	typedef struct packed {
		logic        func;
		logic [2:0]  read_slot;
		entry_t      share;
	} share_req_t;

	// one result beat, predicted or seen on the ports
	typedef struct packed {
		logic [3:0]  slot;
		logic [3:0]  fill;
		entry_t      share;
	} board_reply_t;

	// receiver stall patterns
	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_pattern_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        out_ready = 1'b0;
	logic        rx_hold_go = 1'b0;
	share_req_t  drv       = '0;

	wire         in_ready;
	wire         out_valid;
	wire  [3:0]  slot;
	wire  [3:0]  fill;
	wire  [63:0] out_diff_bits;
	wire  [31:0] out_submit_time;
	wire  [31:0] out_block_time;
	wire  [31:0] out_nonce;
	wire  [31:0] out_version_word;
	wire         out_version_rolled;
	wire  [63:0] out_hash_top;
	wire         out_hash_present;
	wire  [63:0] out_extra_nonce;
	wire  [3:0]  out_extra_nonce_len;

	// shadow of the board contents, highest key in entry 0
	entry_t       shadow_board [BOARD_ENTRIES];
	int unsigned  shadow_fill = 0;

	// requests waiting for the driver and results still owed by the block
	share_req_t   share_backlog[$];
	board_reply_t predicted_replies[$];

	// recent keys, reused so that equal keys meet on the board
	logic [63:0]  key_pool [8];

	int unsigned  mismatch_count = 0;
	int unsigned  reply_count    = 0;
	int unsigned  idle_cycles    = 0;
	int unsigned  burst_left;
	int unsigned  gap_left;
	int unsigned  rx_cycle;
	int unsigned  rx_hold_left;
	bit           rx_hold_done;
	rx_pattern_t  rx_pattern;

	top_n_best_share_board DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.func                (drv.func),
		.read_slot           (drv.read_slot),
		.diff_bits           (drv.share.key),
		.submit_time         (drv.share.submit_time),
		.block_time          (drv.share.block_time),
		.share_nonce         (drv.share.nonce),
		.version_word        (drv.share.version_word),
		.version_was_rolled  (drv.share.ver_rolled),
		.hash_top            (drv.share.hash_top),
		.hash_present        (drv.share.hash_present),
		.extra_nonce         (drv.share.extra_nonce),
		.extra_nonce_len     (drv.share.extra_nonce_len),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.slot                (slot),
		.fill                (fill),
		.out_diff_bits       (out_diff_bits),
		.out_submit_time     (out_submit_time),
		.out_block_time      (out_block_time),
		.out_nonce           (out_nonce),
		.out_version_word    (out_version_word),
		.out_version_rolled  (out_version_rolled),
		.out_hash_top        (out_hash_top),
		.out_hash_present    (out_hash_present),
		.out_extra_nonce     (out_extra_nonce),
		.out_extra_nonce_len (out_extra_nonce_len)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// apply one accepted beat to the shadow board and return its result
	function automatic board_reply_t board_apply(share_req_t r);
		board_reply_t res;
		entry_t       fresh;
		int           i;
		int           pos;
		int           new_fill;
		int unsigned  len;
		logic [63:0]  emask;
		bit           take;
		res      = '0;
		res.slot = 4'(BOARD_ENTRIES);
		res.fill = 4'(shadow_fill);
		if (r.func == FUNC_READ) begin
			// slots at or above the fill read back as empty
			if (r.read_slot < shadow_fill) begin
				res.slot  = 4'(r.read_slot);
				res.share = shadow_board[r.read_slot];
			end
		end else begin
			// negative, infinite and nan keys never go in
			take = !r.share.key[63] && (r.share.key[62:52] != EXP_ALL_ONES);
			// full board: key must strictly beat the last entry
			if (take && shadow_fill == BOARD_ENTRIES &&
					r.share.key <= shadow_board[BOARD_ENTRIES - 1].key)
				take = 1'b0;
			if (take) begin
				// first entry with a strictly smaller key, equal keys stay ahead
				pos = shadow_fill;
				for (i = shadow_fill - 1; i >= 0; i--)
					if (r.share.key > shadow_board[i].key)
						pos = i;
				new_fill = (shadow_fill == BOARD_ENTRIES) ? BOARD_ENTRIES : shadow_fill + 1;
				for (i = new_fill - 1; i > pos; i--)
					shadow_board[i] = shadow_board[i - 1];
				// extranonce length clamps to capacity, unused bytes stored as zero
				len = r.share.extra_nonce_len;
				if (len > EXTRA_BYTES)
					len = EXTRA_BYTES;
				emask = (len >= 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
				fresh                 = r.share;
				fresh.hash_top        = r.share.hash_present ? r.share.hash_top : '0;
				fresh.extra_nonce     = r.share.extra_nonce & emask;
				fresh.extra_nonce_len = 4'(len);
				shadow_board[pos] = fresh;
				shadow_fill       = new_fill;
				res.slot          = 4'(pos);
				res.fill          = 4'(new_fill);
			end
		end
		return res;
	endfunction

	// insert beat with every field random
	function automatic share_req_t rand_share();
		share_req_t r;
		r.func                  = FUNC_INSERT;
		r.read_slot             = 3'($urandom_range(0, 7));
		r.share.key             = {$urandom, $urandom};
		r.share.submit_time     = $urandom;
		r.share.block_time      = $urandom;
		r.share.nonce           = $urandom;
		r.share.version_word    = $urandom;
		r.share.ver_rolled      = 1'($urandom_range(0, 1));
		r.share.hash_top        = {$urandom, $urandom};
		r.share.hash_present    = 1'($urandom_range(0, 1));
		r.share.extra_nonce     = {$urandom, $urandom};
		r.share.extra_nonce_len = 4'($urandom_range(0, 15));
		return r;
	endfunction

	task automatic queue_insert(input logic [63:0] key, input logic [3:0] len,
			input logic hp);
		share_req_t r;
		r                       = rand_share();
		r.share.key             = key;
		r.share.extra_nonce_len = len;
		r.share.hash_present    = hp;
		share_backlog.push_back(r);
	endtask

	task automatic queue_read(input logic [2:0] s);
		share_req_t r;
		r           = rand_share();
		r.func      = FUNC_READ;
		r.read_slot = s;
		share_backlog.push_back(r);
	endtask

	// mostly rising keys so that new shares keep landing on a full board,
	// plus reads, equal keys, low keys, insane keys and fully random bit patterns
	function automatic share_req_t make_random_share(int idx);
		share_req_t  r;
		int          base;
		int unsigned pick;
		r    = rand_share();
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			r.func = FUNC_READ;
		end else if (pick < 70) begin
			base = idx - int'($urandom_range(0, 24));
			if (base < 0)
				base = 0;
			r.share.key = {1'b0, 19'(base), 12'($urandom), 32'($urandom)};
			key_pool[$urandom_range(0, 7)] = r.share.key;
		end else if (pick < 80) begin
			r.share.key = key_pool[$urandom_range(0, 7)];
		end else if (pick < 88) begin
			r.share.key = {$urandom, $urandom};
		end else if (pick < 94) begin
			// sign set or all-ones exponent with random rest
			if ($urandom_range(0, 1))
				r.share.key[63] = 1'b1;
			else
				r.share.key[62:52] = EXP_ALL_ONES;
		end else begin
			r.share.key = 64'($urandom_range(0, 1000));
		end
		return r;
	endfunction

	// wait until nothing is queued, offered or owed
	task automatic wait_board_idle();
		@(negedge clk);
		while (share_backlog.size() != 0 || in_valid || predicted_replies.size() != 0)
			@(negedge clk);
	endtask

	task automatic compare_field(input string fname, input logic [63:0] want,
			input logic [63:0] got, inout bit bad);
		if (want !== got) begin
			bad = 1'b1;
			if (mismatch_count < REPORT_LIMIT)
				$display("result beat %0d %s: expected %h actual %h",
					reply_count, fname, want, got);
		end
	endtask

	// driver: bursts of random length with random gaps, payload held until taken
	always @(posedge clk or negedge arst_n) begin : driver
		if (!arst_n) begin
			in_valid   <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (share_backlog.size() != 0) begin
				drv      <= share_backlog.pop_front();
				in_valid <= 1'b1;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 32);
					// mostly short gaps or none, now and then a long one
					gap_left   <= ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40)
						: $urandom_range(0, 6);
				end else
					burst_left <= burst_left - 1;
			end else
				in_valid <= 1'b0;
		end
	end

	// receiver: stall pattern picked at random, one long hold-off on request
	always @(posedge clk or negedge arst_n) begin : receiver
		if (!arst_n) begin
			out_ready    <= 1'b0;
			rx_cycle     <= 0;
			rx_pattern   <= RX_OPEN;
			rx_hold_left <= 0;
			rx_hold_done <= 1'b0;
		end else begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle % 64 == 0)
				rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
			if (rx_hold_go && !rx_hold_done) begin
				rx_hold_done <= 1'b1;
				rx_hold_left <= RX_HOLD_CYCLES;
				out_ready    <= 1'b0;
			end else if (rx_hold_left != 0) begin
				rx_hold_left <= rx_hold_left - 1;
				out_ready    <= 1'b0;
			end else begin
				case (rx_pattern)
					RX_OPEN:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= (rx_cycle % 8) < 4;
				endcase
			end
		end
	end

	// monitor: check the output beat against the oldest prediction, then
	// predict the input beat taken at this edge
	always @(posedge clk) begin : monitor
		board_reply_t got;
		board_reply_t want;
		bit           bad;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.slot                  = slot;
				got.fill                  = fill;
				got.share.key             = out_diff_bits;
				got.share.submit_time     = out_submit_time;
				got.share.block_time      = out_block_time;
				got.share.nonce           = out_nonce;
				got.share.version_word    = out_version_word;
				got.share.ver_rolled      = out_version_rolled;
				got.share.hash_top        = out_hash_top;
				got.share.hash_present    = out_hash_present;
				got.share.extra_nonce     = out_extra_nonce;
				got.share.extra_nonce_len = out_extra_nonce_len;
				if (predicted_replies.size() == 0) begin
					// result beat that no request asked for
					if (mismatch_count < REPORT_LIMIT)
						$display("result beat %0d arrived with none expected", reply_count);
					mismatch_count++;
				end else begin
					want = predicted_replies.pop_front();
					bad  = 1'b0;
					compare_field("slot", want.slot, got.slot, bad);
					compare_field("fill", want.fill, got.fill, bad);
					compare_field("out_diff_bits", want.share.key, got.share.key, bad);
					compare_field("out_submit_time", want.share.submit_time,
						got.share.submit_time, bad);
					compare_field("out_block_time", want.share.block_time,
						got.share.block_time, bad);
					compare_field("out_nonce", want.share.nonce, got.share.nonce, bad);
					compare_field("out_version_word", want.share.version_word,
						got.share.version_word, bad);
					compare_field("out_version_rolled", want.share.ver_rolled,
						got.share.ver_rolled, bad);
					compare_field("out_hash_top", want.share.hash_top,
						got.share.hash_top, bad);
					compare_field("out_hash_present", want.share.hash_present,
						got.share.hash_present, bad);
					compare_field("out_extra_nonce", want.share.extra_nonce,
						got.share.extra_nonce, bad);
					compare_field("out_extra_nonce_len", want.share.extra_nonce_len,
						got.share.extra_nonce_len, bad);
					if (bad)
						mismatch_count++;
				end
				reply_count++;
			end
			if (in_valid && in_ready)
				predicted_replies.push_back(board_apply(drv));
		end
	end

	// watchdog: too long without a beat on either channel means a hang
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("top_n_best_share_board test failed");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int i;
		for (i = 0; i < 8; i++)
			key_pool[i] = 64'h3FF0_0000_0000_0000;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// empty board: reads past fill, insane keys
		queue_read(3'd0);
		queue_read(3'd7);
		queue_insert(64'h8000_0000_0000_0001, 4'd3, 1'b1); // negative
		queue_insert(64'h7FF0_0000_0000_0000, 4'd8, 1'b1); // infinity
		queue_insert(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1); // nan with sign
		// fill up: zero key, top finite key, equal keys, length clamp, no hash
		queue_insert(64'h0, 4'd0, 1'b0);
		queue_insert(TOP_FINITE_KEY, 4'd15, 1'b1);
		queue_insert(64'h3FF0_0000_0000_0000, 4'd9, 1'b0);
		queue_insert(64'h3FF0_0000_0000_0000, 4'd8, 1'b1);
		queue_insert(64'h3FF0_0000_0000_0000, 4'd1, 1'b1);
		queue_insert(64'h4000_0000_0000_0000, 4'd4, 1'b0);
		queue_insert(64'h1, 4'd7, 1'b1);
		queue_insert(64'h0010_0000_0000_0000, 4'd3, 1'b1);
		// full board: tie with the last entry, insane key, just beating the
		// last entry, tie with the first entry
		queue_insert(64'h0, 4'd2, 1'b1);
		queue_insert(64'h8000_0000_0000_0000, 4'd2, 1'b1);
		queue_insert(64'h2, 4'd5, 1'b1);
		queue_insert(TOP_FINITE_KEY, 4'd6, 1'b0);
		for (i = 0; i < 8; i++)
			queue_read(3'(i));

		// sender pause until every result is back
		wait_board_idle();
		repeat ($urandom_range(3, 12)) @(posedge clk);

		for (i = 0; i < RANDOM_SHARES / 2; i++)
			share_backlog.push_back(make_random_share(DIRECTED_SHARES + i));
		// long receiver hold while the sender keeps offering
		@(negedge clk);
		rx_hold_go <= 1'b1;
		for (i = RANDOM_SHARES / 2; i < RANDOM_SHARES; i++)
			share_backlog.push_back(make_random_share(DIRECTED_SHARES + i));

		wait_board_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("top_n_best_share_board test passed");
		else
			$display("top_n_best_share_board test failed");
		$finish;
	end

endmodule
